### sv/utf8ld_pkg.sv
// Package for the UTF-8 line decoder: request/response payload types,
// decoder state type and byte-class constants. No dependencies.
package utf8ld_pkg;

   localparam logic [7:0] LEAD_ASCII_MASK = 8'h80;
   localparam logic [7:0] LEAD_3B_MASK    = 8'hE0;
   localparam logic [7:0] LEAD_2B_MASK    = 8'hC0;
   localparam logic [7:0] LOW4_MASK       = 8'h0F;
   localparam logic [7:0] LOW5_MASK       = 8'h1F;
   localparam logic [7:0] LOW6_MASK       = 8'h3F;

   localparam logic [15:0] CHAR_NL  = 16'h000A;
   localparam logic [15:0] CHAR_CR  = 16'h000D;
   localparam logic [15:0] CHAR_NUL = 16'h0000;

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [15:0] code_point;
      logic        char_valid;
      logic        end_of_line;
      logic        bad_sequence;
   } rsp_type;

   typedef struct packed {
      logic [1:0] bytes_pending;
      logic [9:0] partial_bits;
   } dec_state_type;

endpackage

### sv/utf8_line_decoder.sv
// Top level of the UTF-8 line decoder: handshake, sequence state and
// response register. Depends on utf8ld_pkg and utf8ld_decode.

// Decodes a UTF-8 byte stream (sequences of up to three bytes) into 16-bit
// code points, one byte per request, and marks line ends at newline or at a
// byte flagged as end of stream. Carriage returns and zeros are dropped;
// lead bytes of multi-byte sequences give no response unless so flagged. A
// request is taken every cycle while the response register is empty or being
// drained, so the block sustains one byte per clock; each response is
// registered. Throughput is set only by the one response register draining.
module utf8_line_decoder import utf8ld_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   dec_state_type state_ff, state_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_present;
   logic          req_take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   utf8ld_decode u_decode (
      .state       (state_ff),
      .req         (req_payload),
      .state_next  (state_in),
      .rsp         (rsp_in),
      .rsp_present (rsp_present)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = rsp_present;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   // hold the response until taken
   always_ff @(posedge clock) begin
      if (req_take && rsp_present) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### sv/utf8ld_decode.sv
// Combinational decode of one byte against the current sequence state.
// Produces the next state and the response, if any. Depends on utf8ld_pkg.
module utf8ld_decode import utf8ld_pkg::*; (
   input  dec_state_type state,
   input  req_type       req,
   output dec_state_type state_next,
   output rsp_type       rsp,
   output logic          rsp_present
);

   logic [15:0] acc;
   logic [15:0] cp;
   logic        have_char;
   logic        bad;
   logic        eol;
   logic        char_ok;
   logic [1:0]  pend_dec;

   assign acc      = {state.partial_bits, req.data_byte[5:0] & LOW6_MASK[5:0]};
   assign pend_dec = state.bytes_pending - 2'd1;

   always_comb begin
      state_next = state;
      cp         = CHAR_NUL;
      have_char  = 1'b0;
      bad        = 1'b0;
      if (state.bytes_pending == PEND_NONE) begin
         if ((req.data_byte & LEAD_ASCII_MASK) == 8'h00) begin
            cp        = {8'h00, req.data_byte};
            have_char = 1'b1;
         end else if ((req.data_byte & LEAD_3B_MASK) == LEAD_3B_MASK) begin
            state_next.bytes_pending = PEND_TWO;
            state_next.partial_bits  = {6'd0, req.data_byte[3:0] & LOW4_MASK[3:0]};
         end else if ((req.data_byte & LEAD_2B_MASK) == LEAD_2B_MASK) begin
            state_next.bytes_pending = PEND_ONE;
            state_next.partial_bits  = {5'd0, req.data_byte[4:0] & LOW5_MASK[4:0]};
         end else begin
            // stray continuation byte: drop it, flag it
            bad = 1'b1;
         end
      end else begin
         state_next.bytes_pending = pend_dec;
         if (pend_dec == PEND_NONE) begin
            cp                      = acc;
            have_char               = 1'b1;
            state_next.partial_bits = 10'd0;
         end else begin
            state_next.partial_bits = acc[9:0];
         end
      end

      eol     = have_char && (cp == CHAR_NL);
      char_ok = have_char && (cp != CHAR_NL) && (cp != CHAR_CR) && (cp != CHAR_NUL);

      if (req.end_of_stream) begin
         eol = 1'b1;
         if (state_next.bytes_pending != PEND_NONE) begin
            bad = 1'b1;
         end
         state_next.bytes_pending = PEND_NONE;
         state_next.partial_bits  = 10'd0;
      end

      rsp.code_point   = char_ok ? cp : CHAR_NUL;
      rsp.char_valid   = char_ok;
      rsp.end_of_line  = eol;
      rsp.bad_sequence = bad;
      rsp_present      = char_ok || eol || bad;
   end

endmodule

### test/utf8_line_decoder_test.sv
// Testbench for utf8_line_decoder: directed and random byte streams, with results
// checked against a behavioral decoder kept in the bench.
// Depends on utf8ld_pkg and the decoder RTL.
`timescale 1ns / 100ps

module utf8_line_decoder_test import utf8ld_pkg::*;;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // decoder state as the bench predicts it
   logic [1:0] pend_count = PEND_NONE;
   logic [9:0] partial_cp = '0;

   rsp_type expected_chars[$];
   int      mismatch_count = 0;
   int      bytes_sent     = 0;
   bit      no_idle        = 1'b0;

   utf8_line_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Advance the predicted state by one byte; emits says whether a response follows.
   function automatic void decode_byte(input req_type rq, output bit emits,
                                       output rsp_type rs);
      logic [15:0] cp;
      logic [15:0] acc;
      bit          have_char;
      bit          shown;
      bit          eol;
      bit          bad;
      cp        = CHAR_NUL;
      have_char = 1'b0;
      shown     = 1'b0;
      eol       = 1'b0;
      bad       = 1'b0;
      if (pend_count == PEND_NONE) begin
         if ((rq.data_byte & LEAD_ASCII_MASK) == 8'h00) begin
            cp        = {8'h00, rq.data_byte};
            have_char = 1'b1;
         end else if ((rq.data_byte & LEAD_3B_MASK) == LEAD_3B_MASK) begin
            pend_count = PEND_TWO;
            partial_cp = 10'(rq.data_byte & LOW4_MASK);
         end else if ((rq.data_byte & LEAD_2B_MASK) == LEAD_2B_MASK) begin
            pend_count = PEND_ONE;
            partial_cp = 10'(rq.data_byte & LOW5_MASK);
         end else begin
            bad = 1'b1;
         end
      end else begin
         acc        = {partial_cp, 6'(rq.data_byte & LOW6_MASK)};
         pend_count = pend_count - 2'd1;
         if (pend_count == PEND_NONE) begin
            cp         = acc;
            partial_cp = '0;
            have_char  = 1'b1;
         end else begin
            partial_cp = acc[9:0];
         end
      end
      if (have_char) begin
         if (cp == CHAR_NL) begin
            eol = 1'b1;
         end else if (cp != CHAR_CR && cp != CHAR_NUL) begin
            shown = 1'b1;
         end
      end
      // stream end closes the line and throws away any unfinished sequence
      if (rq.end_of_stream) begin
         eol = 1'b1;
         if (pend_count != PEND_NONE) begin
            bad = 1'b1;
         end
         pend_count = PEND_NONE;
         partial_cp = '0;
      end
      emits           = shown || eol || bad;
      rs.code_point   = shown ? cp : CHAR_NUL;
      rs.char_valid   = shown;
      rs.end_of_line  = eol;
      rs.bad_sequence = bad;
   endfunction

   // Entered and left at a falling edge; valid stays high on return.
   task automatic send_byte(input logic [7:0] data, input logic eos);
      req_type rq;
      rsp_type rs;
      bit      emits;
      if (!no_idle) begin
         while ($urandom_range(99) < 33) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      rq.data_byte     = data;
      rq.end_of_stream = eos;
      req_valid   <= 1'b1;
      req_payload <= rq;
      do @(posedge clock); while (!req_ready);
      decode_byte(rq, emits, rs);
      if (emits) begin
         expected_chars.push_back(rs);
      end
      bytes_sent++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin : check_chars
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected response %h", rsp_payload));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_payload.code_point !== want.code_point)
               report_mismatch($sformatf("code_point %h, want %h",
                                         rsp_payload.code_point, want.code_point));
            if (rsp_payload.char_valid !== want.char_valid)
               report_mismatch($sformatf("char_valid %b, want %b",
                                         rsp_payload.char_valid, want.char_valid));
            if (rsp_payload.end_of_line !== want.end_of_line)
               report_mismatch($sformatf("end_of_line %b, want %b",
                                         rsp_payload.end_of_line, want.end_of_line));
            if (rsp_payload.bad_sequence !== want.bad_sequence)
               report_mismatch($sformatf("bad_sequence %b, want %b",
                                         rsp_payload.bad_sequence, want.bad_sequence));
         end
      end
   end

   function automatic logic [7:0] rand_continuation();
      // top bits are not checked by the decoder, so vary them now and then
      if ($urandom_range(99) < 20) begin
         return 8'($urandom_range(255));
      end
      return 8'h80 | 8'($urandom_range(63));
   endfunction

   task automatic send_random_char();
      int unsigned kind;
      kind = $urandom_range(99);
      if (kind < 6) begin
         send_byte(8'h0A, $urandom_range(99) < 3);
      end else if (kind < 9) begin
         send_byte(8'h0D, $urandom_range(99) < 3);
      end else if (kind < 40) begin
         send_byte(8'($urandom_range(127)), $urandom_range(99) < 3);
      end else if (kind < 62) begin
         send_byte(8'hC0 | 8'($urandom_range(31)), $urandom_range(99) < 3);
         send_byte(rand_continuation(), $urandom_range(99) < 3);
      end else if (kind < 85) begin
         send_byte(8'hE0 | 8'($urandom_range(31)), $urandom_range(99) < 3);
         send_byte(rand_continuation(), $urandom_range(99) < 3);
         send_byte(rand_continuation(), $urandom_range(99) < 3);
      end else if (kind < 92) begin
         send_byte(8'h80 | 8'($urandom_range(63)), $urandom_range(99) < 3);
      end else begin
         send_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
      end
   endtask

   task automatic test_ascii();
      send_byte(8'h41, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h0D, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h0A, 1'b0);
   endtask

   task automatic test_two_byte();
      send_byte(8'hC2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // overlong newline still ends the line
      send_byte(8'hC0, 1'b0);
      send_byte(8'h8A, 1'b0);
   endtask

   task automatic test_three_byte();
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // lead above 0xEF and continuations with wrong top bits
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hC0, 1'b0);
   endtask

   task automatic test_stray_continuation();
      send_byte(8'h80, 1'b0);
      send_byte(8'hBF, 1'b0);
   endtask

   task automatic test_stream_end();
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
      send_byte(8'h0D, 1'b1);
      send_byte(8'hC3, 1'b1);
      send_byte(8'h7A, 1'b1);
   endtask

   task automatic test_random_text();
      int stop_at;
      stop_at = bytes_sent + 450;
      while (bytes_sent < stop_at) begin
         send_random_char();
      end
   endtask

   task automatic test_back_to_back();
      int stop_at;
      stop_at = bytes_sent + 100;
      no_idle = 1'b1;
      while (bytes_sent < stop_at) begin
         send_random_char();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      int waited;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_ascii();
      test_two_byte();
      test_three_byte();
      test_stray_continuation();
      test_stream_end();
      test_random_text();
      test_back_to_back();
      req_valid <= 1'b0;
      waited = 0;
      while (expected_chars.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_chars.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", expected_chars.size()));
      end
      // catch any stray response after the last expected one
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
